// ===== sv/suks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suks_pkg: shared types and constants of the sorted unique key store
// Field widths, command and status codes, and the control beat that the
// top level broadcasts to every cell of the key chain.
// ----------------------------------------------------------------------------
package suks_pkg;

    localparam int KEY_W       = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_W     = 6;
    localparam int MAX_RESULTS = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register index as seen in paddr[2]
    localparam logic REG_IDX_DESCENDING = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_LISTED    = 3'd5,
        STAT_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD      = 3'd0,
        CELL_COMPARE   = 3'd1,
        CELL_INSERT    = 3'd2,
        CELL_REMOVE    = 3'd3,
        CELL_ROT_LEFT  = 3'd4,
        CELL_ROT_RIGHT = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/suks_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suks_in_if: command channel of the sorted unique key store
// Valid/ready channel carrying one command and one key per beat.
// ----------------------------------------------------------------------------
interface suks_in_if
    import suks_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface
`default_nettype wire

// ===== sv/suks_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suks_out_if: result channel of the sorted unique key store
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface suks_out_if
    import suks_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] out_key;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_W-1:0]      entry_count;
    logic                    last;

    modport source (output valid, output out_key, output status, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input out_key, input status, input entry_count,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== sv/suks_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suks_cell: one slot of the sorted key chain
// Holds one key, compares it against the broadcast key, and takes a key from
// a neighbor on insert, remove and rotate, or the broadcast key on insert.
// ----------------------------------------------------------------------------
module suks_cell
    import suks_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
)
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic [KEY_W-1:0] prev_key,
    input  wire logic [KEY_W-1:0] next_key,
    input  wire logic             lt_prev,
    output logic [KEY_W-1:0]      key,
    output logic                  lt,
    output logic                  eq
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic             lt_reg, lt_next;
    logic             eq_reg, eq_next;
    logic             occupied;

    assign occupied = (count > CNT_W'(IDX));

    always_comb
    begin
        key_next = key_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
            end
            CELL_COMPARE:
            begin
                lt_next = occupied && ($signed(key_reg) < $signed(ctl.key));
                eq_next = occupied && (key_reg == ctl.key);
            end
            CELL_INSERT:
            begin
                // first slot not below the key takes it, the rest shift up
                if (!lt_reg)
                    key_next = lt_prev ? ctl.key : prev_key;
            end
            CELL_REMOVE:
            begin
                if (!lt_reg)
                    key_next = next_key;
            end
            CELL_ROT_LEFT:  key_next = next_key;
            CELL_ROT_RIGHT: key_next = prev_key;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule
`default_nettype wire

// ===== sv/sorted_unique_key_store_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_key_store_unit: sorted store of distinct signed keys
// Insert, remove and dump commands over a chain of key cells kept in
// ascending order; one result per insert/remove, per key to MAX_RESULTS on dump.
// ----------------------------------------------------------------------------
//
//  Channel    Dir   Handshake            Payload
//  ---------  ----  -------------------  -----------------------------------
//  item_in    in    valid/ready          command, key
//  result_out out   valid/ready          out_key, status, entry_count, last
//  apb        in    psel/penable/pready  paddr, pwdata, pwrite -> prdata
//
//  Insert and remove: the accept cycle compares the key in every cell at once,
//  then the apply step shifts the chain and loads the result register. A dump
//  goes through the apply step, then rotates the chain once around all CAPACITY
//  cells, one step per cycle while not stalled; keys are taken from an end cell.
//  A result waiting in the output register stalls apply and key-due rotates.
//  Reset clears the count, the dump order and the controller; the key cells
//  need no clearing, since only cells below the count are ever reported.
//
module sorted_unique_key_store_unit
    import suks_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    suks_in_if.sink                    item_in,
    suks_out_if.source                 result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int EW = ((CW > ENTRY_W) ? CW : ENTRY_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_DUMP  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       step_reg, step_next;
    logic                desc_reg, desc_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    status_t             out_status_reg, out_status_next;
    logic [ENTRY_W-1:0]  out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;

    cell_ctl_t           ctl;
    logic [KEY_W-1:0]    cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;

    logic                in_accept;
    logic                cmd_ok;
    logic                out_free;
    logic                hit;
    logic                full;
    logic                ins_ok;
    logic                load;
    logic                cfg_write;

    logic [EW-1:0]       count_ext;
    logic [EW-1:0]       step_sum;
    logic [EW-1:0]       emit_idx;
    logic [EW-1:0]       dump_len;
    logic                in_window;
    logic                emit;
    logic                dump_last;
    logic [KEY_W-1:0]    dump_key;

    // ---------------------------------------------------------------- cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? CAPACITY - 1 : i - 1;
        localparam int NEXT = (i == CAPACITY - 1) ? 0 : i + 1;
        logic lt_prev;
        if (i == 0)
        begin : g_head
            assign lt_prev = 1'b1;
        end
        else
        begin : g_body
            assign lt_prev = cell_lt[i-1];
        end

        suks_cell #(
            .IDX   (i),
            .CNT_W (CW)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .count    (count_reg),
            .prev_key (cell_key[PREV]),
            .next_key (cell_key[NEXT]),
            .lt_prev  (lt_prev),
            .key      (cell_key[i]),
            .lt       (cell_lt[i]),
            .eq       (cell_eq[i])
        );
    end

    // ------------------------------------------------------------ handshake
    assign item_in.ready = (state_reg == S_IDLE);
    assign in_accept     = item_in.valid && item_in.ready;
    assign cmd_ok        = (item_in.command == CMD_INSERT) ||
                           (item_in.command == CMD_REMOVE) ||
                           (item_in.command == CMD_DUMP);
    assign out_free      = !out_valid_reg || result_out.ready;

    assign hit    = |cell_eq;
    assign full   = (count_reg >= CW'(CAPACITY));
    assign ins_ok = !hit && !full;

    // ----------------------------------------------------- dump sequencing
    // Ascending: rotate left, cell 0 shows key[step].
    // Descending: rotate right, the end cell shows key[CAPACITY-1-step].
    assign count_ext = EW'(count_reg);
    assign step_sum  = EW'(step_reg) + count_ext;
    assign in_window = !desc_reg || (step_sum >= EW'(CAPACITY));
    assign emit_idx  = desc_reg ? (step_sum - EW'(CAPACITY)) : EW'(step_reg);
    assign dump_len  = (count_ext > EW'(MAX_RESULTS)) ? EW'(MAX_RESULTS) : count_ext;
    assign emit      = in_window && (emit_idx < dump_len);
    assign dump_last = (emit_idx + EW'(1)) == dump_len;
    assign dump_key  = desc_reg ? cell_key[CAPACITY-1] : cell_key[0];

    // -------------------------------------------------------- configuration
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_IDX_DESCENDING) ?
                       {{(APB_DATA_W-1){1'b0}}, desc_reg} : '0;

    // ----------------------------------------------------------- controller
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        desc_next       = desc_reg;
        ctl.op          = CELL_HOLD;
        ctl.key         = key_reg;
        load            = 1'b0;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (cfg_write && (paddr[2] == REG_IDX_DESCENDING))
            desc_next = pwdata[0];

        unique case (state_reg)
            S_IDLE:
            begin
                // compare against the incoming key right away
                ctl.key = item_in.key;
                if (in_accept)
                begin
                    ctl.op = CELL_COMPARE;
                    if (cmd_ok)
                        state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    load           = 1'b1;
                    out_key_next   = '0;
                    out_last_next  = 1'b1;
                    out_count_next = ENTRY_W'(count_reg);
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (hit)
                                out_status_next = STAT_DUPLICATE;
                            else if (full)
                                out_status_next = STAT_FULL;
                            else
                            begin
                                ctl.op          = CELL_INSERT;
                                count_next      = count_reg + CW'(1);
                                out_status_next = STAT_INSERTED;
                                out_key_next    = key_reg;
                                out_count_next  = ENTRY_W'(count_reg + CW'(1));
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (hit)
                            begin
                                ctl.op          = CELL_REMOVE;
                                count_next      = count_reg - CW'(1);
                                out_status_next = STAT_REMOVED;
                                out_key_next    = key_reg;
                                out_count_next  = ENTRY_W'(count_reg - CW'(1));
                            end
                            else
                                out_status_next = STAT_NOT_FOUND;
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                // no result yet: walk the chain first
                                load       = 1'b0;
                                state_next = S_DUMP;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // advance unless a key is due and the output is still full
                if (!emit || out_free)
                begin
                    ctl.op    = desc_reg ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
                    step_next = step_reg + SW'(1);
                    if (emit)
                    begin
                        load            = 1'b1;
                        out_key_next    = dump_key;
                        out_status_next = STAT_LISTED;
                        out_count_next  = ENTRY_W'(count_reg);
                        out_last_next   = dump_last;
                    end
                    if (step_reg == SW'(CAPACITY - 1))
                    begin
                        step_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !result_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            desc_reg      <= desc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the command beat and the result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= item_in.command;
            key_reg <= item_in.key;
        end
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.out_key     = out_key_reg;
    assign result_out.status      = out_status_reg;
    assign result_out.entry_count = out_count_reg;
    assign result_out.last        = out_last_reg;

    // ----------------------------------------------------------- assertions
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("key count exceeds capacity");

    a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) && out_free && (cmd_reg == CMD_INSERT) && ins_ok
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance the count");

    a_dump_count : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(count_reg))
        else $error("count changed during a dump");

    a_dump_load : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) && load |-> out_status_next == STAT_LISTED)
        else $error("dump loaded a non-listing result");

    for (genvar j = 0; j < CAPACITY - 1; j++)
    begin : g_order_chk
        a_sorted : assert property (@(posedge clk) disable iff (!rst_n)
            (state_reg == S_IDLE) && (count_reg > CW'(j + 1))
            |-> $signed(cell_key[j]) < $signed(cell_key[j+1]))
            else $error("stored keys out of order");
    end

endmodule
`default_nettype wire
